@@ rtl/core/plp_pkg.sv @@
// ----------------------------------------------------------------------------
// plp_pkg
// shared types, character codes and helpers for the property list line parser
// ----------------------------------------------------------------------------
package plp_pkg;

  localparam int CP_W       = 21;
  localparam int OUT_CNT_W  = 16;
  localparam int KIND_W     = 2;
  localparam int NAME_VEC_W = 256;
  localparam int NAME_LEN_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SHIFT_MAX = 21'h010FFF;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_NAME_0   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NAME_1   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NAME_2   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_NAME_3   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_NAME_LEN = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_RANGE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR   = 2'd2;

  // characters
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [10:0] {
    PH_LINE_START        = 11'b000_0000_0001,
    PH_FIRST             = 11'b000_0000_0010,
    PH_DOT               = 11'b000_0000_0100,
    PH_BEFORE_SECOND     = 11'b000_0000_1000,
    PH_SECOND            = 11'b000_0001_0000,
    PH_SPACES            = 11'b000_0010_0000,
    PH_SPACE_BEFORE_NAME = 11'b000_0100_0000,
    PH_NAME              = 11'b000_1000_0000,
    PH_SPACE_AFTER_NAME  = 11'b001_0000_0000,
    PH_COMMENT           = 11'b010_0000_0000,
    PH_ERROR             = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [CP_W-1:0]      first;
    logic [CP_W-1:0]      last;
    logic [OUT_CNT_W-1:0] count;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // uppercase hex digit decode: bit 4 set when the byte is a digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDER);
  endfunction

endpackage

@@ rtl/core/plp_front.sv @@
// ----------------------------------------------------------------------------
// plp_front
// line grammar state machine; classifies each byte and pushes results
// ----------------------------------------------------------------------------
module plp_front #(
  parameter int MAX_NAME_CHARS = 32,
  parameter int COUNT_BITS     = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [7:0]                      char_byte,
  input  logic                            end_of_stream,
  input  logic [plp_pkg::NAME_VEC_W-1:0]  name_vec,
  input  logic [plp_pkg::NAME_LEN_W-1:0]  name_length,
  output plp_pkg::push_t                  push
);

  localparam int POS_W = $clog2(MAX_NAME_CHARS + 1);
  localparam logic [plp_pkg::NAME_LEN_W-1:0] MAX_LEN = plp_pkg::NAME_LEN_W'(MAX_NAME_CHARS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  plp_pkg::phase_t            phase, phase_next;
  logic [plp_pkg::CP_W-1:0]   first_cp, first_cp_next;
  logic [plp_pkg::CP_W-1:0]   last_cp, last_cp_next;
  logic [POS_W-1:0]           name_pos, name_pos_next;
  logic                       name_equal, name_equal_next;
  logic [COUNT_BITS-1:0]      count, count_next;

  logic [4:0]                          hex;
  logic [plp_pkg::NAME_LEN_W-1:0]      wlen;
  logic [plp_pkg::NAME_LEN_W-1:0]      pos_ext;
  logic [7:0]                          want_char;
  logic [COUNT_BITS-1:0]               count_inc;
  logic [COUNT_BITS-1:0]               count_sel;
  logic [plp_pkg::OUT_CNT_W-1:0]       count_out;

  assign hex       = plp_pkg::hex_decode(char_byte);
  assign wlen      = (name_length > MAX_LEN) ? MAX_LEN : name_length;
  assign pos_ext   = plp_pkg::NAME_LEN_W'(name_pos);
  assign want_char = name_vec[{pos_ext[4:0], 3'b000} +: 8];
  assign count_inc = (count == COUNT_MAX) ? count : count + 1'b1;
  assign count_sel = end_of_stream ? count : count_inc;

  generate
    if (COUNT_BITS >= plp_pkg::OUT_CNT_W) begin : g_cnt_trunc
      assign count_out = count_sel[plp_pkg::OUT_CNT_W-1:0];
    end else begin : g_cnt_ext
      assign count_out = {{(plp_pkg::OUT_CNT_W-COUNT_BITS){1'b0}}, count_sel};
    end
  endgenerate

  always_comb begin
    phase_next      = phase;
    first_cp_next   = first_cp;
    last_cp_next    = last_cp;
    name_pos_next   = name_pos;
    name_equal_next = name_equal;
    count_next      = count;
    push            = '0;
    push.data.count = count_out;
    if (accept) begin
      if (end_of_stream) begin
        push.valid      = 1'b1;
        push.data.kind  = (phase == plp_pkg::PH_LINE_START) ? plp_pkg::KIND_OK
                                                            : plp_pkg::KIND_ERR;
        phase_next      = plp_pkg::PH_LINE_START;
        first_cp_next   = '0;
        last_cp_next    = '0;
        name_pos_next   = '0;
        name_equal_next = 1'b0;
        count_next      = '0;
      end else begin
        case (phase)
          plp_pkg::PH_LINE_START: begin
            if (hex[4]) begin
              first_cp_next = plp_pkg::CP_W'(hex[3:0]);
              phase_next    = plp_pkg::PH_FIRST;
            end else if (char_byte == plp_pkg::CH_HASH) begin
              phase_next = plp_pkg::PH_COMMENT;
            end else if (char_byte != plp_pkg::CH_LF) begin
              phase_next = plp_pkg::PH_ERROR;
            end
          end
          plp_pkg::PH_FIRST: begin
            if (hex[4]) begin
              if (first_cp > plp_pkg::CP_SHIFT_MAX) begin
                phase_next = plp_pkg::PH_ERROR;
              end else begin
                first_cp_next = {first_cp[16:0], hex[3:0]};
              end
            end else if (char_byte == plp_pkg::CH_DOT) begin
              phase_next = plp_pkg::PH_DOT;
            end else if (char_byte == plp_pkg::CH_SPACE) begin
              last_cp_next = first_cp;
              phase_next   = plp_pkg::PH_SPACES;
            end else begin
              phase_next = plp_pkg::PH_ERROR;
            end
          end
          plp_pkg::PH_DOT: begin
            phase_next = (char_byte == plp_pkg::CH_DOT) ? plp_pkg::PH_BEFORE_SECOND
                                                        : plp_pkg::PH_ERROR;
          end
          plp_pkg::PH_BEFORE_SECOND: begin
            if (hex[4]) begin
              last_cp_next = plp_pkg::CP_W'(hex[3:0]);
              phase_next   = plp_pkg::PH_SECOND;
            end else begin
              phase_next = plp_pkg::PH_ERROR;
            end
          end
          plp_pkg::PH_SECOND: begin
            if (hex[4]) begin
              if (last_cp > plp_pkg::CP_SHIFT_MAX) begin
                phase_next = plp_pkg::PH_ERROR;
              end else begin
                last_cp_next = {last_cp[16:0], hex[3:0]};
              end
            end else if (char_byte == plp_pkg::CH_SPACE) begin
              phase_next = plp_pkg::PH_SPACES;
            end else if (char_byte == plp_pkg::CH_SEMI) begin
              phase_next = plp_pkg::PH_SPACE_BEFORE_NAME;
            end else begin
              phase_next = plp_pkg::PH_ERROR;
            end
          end
          plp_pkg::PH_SPACES: begin
            if (char_byte == plp_pkg::CH_SEMI) begin
              phase_next = plp_pkg::PH_SPACE_BEFORE_NAME;
            end else if (char_byte != plp_pkg::CH_SPACE) begin
              phase_next = plp_pkg::PH_ERROR;
            end
          end
          plp_pkg::PH_SPACE_BEFORE_NAME: begin
            if (char_byte == plp_pkg::CH_SPACE) begin
              phase_next      = plp_pkg::PH_NAME;
              name_pos_next   = '0;
              name_equal_next = 1'b1;
            end else begin
              phase_next = plp_pkg::PH_ERROR;
            end
          end
          plp_pkg::PH_NAME: begin
            if (plp_pkg::is_name_char(char_byte)) begin
              if (name_equal && (pos_ext < wlen) && (char_byte == want_char)) begin
                name_pos_next = name_pos + 1'b1;
              end else begin
                name_equal_next = 1'b0;
              end
            end else if (char_byte == plp_pkg::CH_SPACE) begin
              phase_next = plp_pkg::PH_SPACE_AFTER_NAME;
              if (name_equal && (pos_ext == wlen)) begin
                // matching name: reversed range is a grammar error
                if (first_cp > last_cp) begin
                  phase_next = plp_pkg::PH_ERROR;
                end else begin
                  count_next      = count_inc;
                  push.valid      = 1'b1;
                  push.data.kind  = plp_pkg::KIND_RANGE;
                  push.data.first = first_cp;
                  push.data.last  = last_cp;
                end
              end else begin
                name_equal_next = 1'b0;
              end
            end else begin
              phase_next = plp_pkg::PH_ERROR;
            end
          end
          plp_pkg::PH_SPACE_AFTER_NAME: begin
            phase_next = (char_byte == plp_pkg::CH_HASH) ? plp_pkg::PH_COMMENT
                                                         : plp_pkg::PH_ERROR;
          end
          plp_pkg::PH_COMMENT: begin
            if (char_byte == plp_pkg::CH_LF) begin
              phase_next = plp_pkg::PH_LINE_START;
            end
          end
          default: begin
            phase_next = plp_pkg::PH_ERROR;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= plp_pkg::PH_LINE_START;
      first_cp   <= '0;
      last_cp    <= '0;
      name_pos   <= '0;
      name_equal <= 1'b0;
      count      <= '0;
    end else begin
      phase      <= phase_next;
      first_cp   <= first_cp_next;
      last_cp    <= last_cp_next;
      name_pos   <= name_pos_next;
      name_equal <= name_equal_next;
      count      <= count_next;
    end
  end

endmodule

@@ rtl/core/plp_queue.sv @@
// ----------------------------------------------------------------------------
// plp_queue
// short result queue between the parser and the output stage
// ----------------------------------------------------------------------------
module plp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  plp_pkg::push_t       push,
  input  logic                 pop,
  output plp_pkg::result_t     head,
  output plp_pkg::q_status_t   status
);

  localparam int PTR_W = (plp_pkg::QUEUE_DEPTH > 1) ? $clog2(plp_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(plp_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(plp_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(plp_pkg::QUEUE_DEPTH);

  plp_pkg::result_t   entries [plp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (fill == CNT_FULL);
  assign status.empty = (fill == '0);
  assign do_push      = push.valid && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/core/plp_back.sv @@
// ----------------------------------------------------------------------------
// plp_back
// output register; drains the result queue onto the master stream
// ----------------------------------------------------------------------------
module plp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  plp_pkg::result_t     head,
  input  logic                 q_empty,
  output logic                 pop,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,
  output logic [1:0]           m_axis_tuser
);

  plp_pkg::result_t  out_reg;

  // register is free when empty or being taken this cycle
  assign pop = !q_empty && (!m_axis_tvalid || m_axis_tready);

  assign m_axis_tuser = out_reg.kind;
  assign m_axis_tdata = {6'd0, out_reg.count, out_reg.last, out_reg.first};

  always_ff @(posedge clk) begin
    if (pop) begin
      out_reg <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

@@ rtl/core/property_list_line_parser_top.sv @@
// ----------------------------------------------------------------------------
// property_list_line_parser_top
// parses a property list text stream and reports ranges of a wanted property
// ----------------------------------------------------------------------------
// Usage: file bytes enter on the slave stream, one byte per beat in tdata;
// tuser high marks the end-of-stream beat (its tdata is ignored). Each line
// "HEX[..HEX] ; Name #comment" whose name equals the configured name gives
// one range beat on the master stream (tuser = kind 0). The end beat gives a
// status beat: kind 1 when the stream ended at a line start with no error,
// kind 2 otherwise, with the match count; the parser then rearms.
// Throughput: one byte per cycle while the queue is not full, set by the grammar
// state machine. A result reaches the master stream from the byte that causes it
// by way of the queue and the output register (parser -> queue -> output register).
// The two-entry queue decouples the sides: when the receiver stalls the
// parser keeps taking bytes until the queue is full, then drops tready.
// Reset (rst, synchronous) clears the parser to line start, empties the
// queue and clears the name registers. Configure only while idle.
// ----------------------------------------------------------------------------
module property_list_line_parser_top #(
  parameter int MAX_NAME_CHARS = 32,
  parameter int COUNT_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [plp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [plp_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // char_byte
  input  logic                              s_axis_tuser,   // end_of_stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // range_first[20:0], range_last[41:21], match_count[57:42], zero pad
  output logic [63:0]                       m_axis_tdata,
  output logic [1:0]                        m_axis_tuser    // result_kind
);

  logic [plp_pkg::CFG_DATA_W-1:0]  name_reg [4];
  logic [plp_pkg::NAME_LEN_W-1:0]  name_length;
  logic [plp_pkg::NAME_VEC_W-1:0]  name_vec;
  logic                            accept;
  plp_pkg::push_t                  push;
  plp_pkg::result_t                head;
  plp_pkg::q_status_t              q_status;
  logic                            pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_reg[0] <= '0;
      name_reg[1] <= '0;
      name_reg[2] <= '0;
      name_reg[3] <= '0;
      name_length <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        plp_pkg::REG_NAME_0:   name_reg[0] <= cfg_wr_data;
        plp_pkg::REG_NAME_1:   name_reg[1] <= cfg_wr_data;
        plp_pkg::REG_NAME_2:   name_reg[2] <= cfg_wr_data;
        plp_pkg::REG_NAME_3:   name_reg[3] <= cfg_wr_data;
        plp_pkg::REG_NAME_LEN: name_length <= cfg_wr_data[plp_pkg::NAME_LEN_W-1:0];
        default:               name_length <= name_length;
      endcase
    end
  end

  assign name_vec      = {name_reg[3], name_reg[2], name_reg[1], name_reg[0]};
  assign s_axis_tready = !q_status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  plp_front #(
    .MAX_NAME_CHARS (MAX_NAME_CHARS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .char_byte     (s_axis_tdata),
    .end_of_stream (s_axis_tuser),
    .name_vec      (name_vec),
    .name_length   (name_length),
    .push          (push)
  );

  plp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  plp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_status.empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // the parser never pushes into a full queue
  assert property (@(posedge clk) disable iff (rst) !(push.valid && q_status.full))
    else $error("result pushed into full queue");

  // an end beat always leaves a status result pending downstream
  assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tuser) |=> (!q_status.empty || m_axis_tvalid))
    else $error("status result lost");

  // a range beat never carries a reversed range
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == plp_pkg::KIND_RANGE)
      |-> (m_axis_tdata[20:0] <= m_axis_tdata[41:21]))
    else $error("reversed range emitted");

endmodule
